### rtl/core/camera_intrinsic_constraint_residuals_defines.svh
// Assertion helpers used by the checker file.
`ifndef CAMERA_INTRINSIC_CONSTRAINT_RESIDUALS_DEFINES_SVH
`define CAMERA_INTRINSIC_CONSTRAINT_RESIDUALS_DEFINES_SVH

// same-cycle implication, off during reset
`define CICR_AST_SAME(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("cicr check failed");

// next-cycle implication, off during reset
`define CICR_AST_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("cicr check failed");

// state right after a reset cycle
`define CICR_AST_RESET(lbl, post) \
   lbl: assert property (@(posedge clock) reset |=> (post)) \
      else $error("cicr reset check failed");

`endif

### rtl/core/cicr_pkg.sv
package cicr_pkg;

   localparam int unsigned IN_W      = 24;
   localparam int unsigned ENT_W     = 21;
   localparam int unsigned CFG_W     = 3 * ENT_W;
   localparam int unsigned NUM_COLS  = 4;
   localparam int unsigned PRD_W     = 46;
   localparam int unsigned A_W       = 47;
   localparam int unsigned MAG_W     = 46;
   localparam int unsigned FRAC_SH   = 16;
   localparam int unsigned QUO_W     = MAG_W + FRAC_SH;
   localparam int unsigned PROD_W    = 2 * QUO_W;
   localparam int unsigned WIDE_W    = 128;
   localparam int unsigned HH_W      = 2 * ENT_W;
   localparam int unsigned HH_SH     = 32;
   localparam int unsigned SQ_W      = 60;
   localparam int unsigned SQP_W     = 2 * SQ_W;
   localparam int unsigned RND_SH    = 56;
   localparam int unsigned OUT_W     = 64;
   localparam int unsigned NUM_DOTS  = 6;
   localparam int unsigned NUM_RES   = 4;
   localparam int unsigned MUL_LAT   = 2;
   localparam int unsigned CSR_IDX_W = 8;
   localparam int unsigned REQ_W     = 4 * IN_W;
   localparam int unsigned RSP_W     = 5 * OUT_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VIEW1_COL0 = 8'd0,
      CSR_VIEW1_COL1 = 8'd1,
      CSR_VIEW2_COL0 = 8'd2,
      CSR_VIEW2_COL1 = 8'd3
   } csr_idx_type;

   function automatic logic [ENT_W-1:0] entry_of(input logic [CFG_W-1:0] r,
                                                 input int unsigned k);
      return r[k*ENT_W +: ENT_W];
   endfunction

endpackage

### rtl/core/cicr_div.sv
module cicr_div #(
   parameter int unsigned NW = cicr_pkg::QUO_W,
   parameter int unsigned DW = cicr_pkg::IN_W,
   parameter int unsigned TW = 1
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   input  logic [TW-1:0] tag,
   output logic [NW-1:0] quotient,
   output logic [TW-1:0] tag_out
);

   logic [DW-1:0] rem_ff [NW];
   logic [NW-1:0] num_ff [NW];
   logic [DW-1:0] den_ff [NW];
   logic [TW-1:0] tag_ff [NW];
   logic [DW-1:0] rem_in [NW];
   logic [NW-1:0] num_in [NW];
   logic [DW-1:0] den_in [NW];
   logic [TW-1:0] tag_in [NW];

   // one quotient bit per stage, restoring
   always_comb begin
      logic [DW-1:0] r;
      logic [NW-1:0] n;
      logic [DW-1:0] d;
      logic [TW-1:0] t;
      logic [DW:0]   trial;
      for (int i = 0; i < NW; i++) begin
         if (i == 0) begin
            r = '0;
            n = dividend;
            d = divisor;
            t = tag;
         end else begin
            r = rem_ff[i-1];
            n = num_ff[i-1];
            d = den_ff[i-1];
            t = tag_ff[i-1];
         end
         trial = {r, n[NW-1]};
         if (trial >= {1'b0, d}) begin
            rem_in[i] = DW'(trial - {1'b0, d});
            num_in[i] = {n[NW-2:0], 1'b1};
         end else begin
            rem_in[i] = trial[DW-1:0];
            num_in[i] = {n[NW-2:0], 1'b0};
         end
         den_in[i] = d;
         tag_in[i] = t;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
         den_ff <= den_in;
         tag_ff <= tag_in;
      end
   end

   assign quotient = num_ff[NW-1];
   assign tag_out  = tag_ff[NW-1];

endmodule

### rtl/core/cicr_mul.sv
module cicr_mul #(
   parameter int unsigned W  = cicr_pkg::QUO_W,
   parameter int unsigned TW = 1
) (
   input  logic            clock,
   input  logic            en,
   input  logic [W-1:0]    a,
   input  logic [W-1:0]    b,
   input  logic [TW-1:0]   tag,
   output logic [2*W-1:0]  prod,
   output logic [TW-1:0]   tag_out
);

   localparam int unsigned H = W / 2;

   logic [W-1:0]   pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic [TW-1:0]  tag1_ff, tag2_ff;
   logic [2*W-1:0] prod_ff;
   logic [W:0]     mid;

   // half-width partial products, then one wide sum
   assign mid = {1'b0, pp01_ff} + {1'b0, pp10_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         pp00_ff <= a[H-1:0] * b[H-1:0];
         pp01_ff <= a[H-1:0] * b[W-1:H];
         pp10_ff <= a[W-1:H] * b[H-1:0];
         pp11_ff <= a[W-1:H] * b[W-1:H];
         tag1_ff <= tag;
         prod_ff <= {pp11_ff, pp00_ff} + ({{(W-1){1'b0}}, mid} << H);
         tag2_ff <= tag1_ff;
      end
   end

   assign prod    = prod_ff;
   assign tag_out = tag2_ff;

endmodule

### rtl/core/camera_intrinsic_constraint_residuals.sv
// Pipeline: 77 stages from input transfer to the last stage, then the output register
// on rsp; the 62-stage pipelined restoring divider makes up most of the stages.
// Throughput: one item per cycle; the pipeline stalls as a whole only when the
// last stage holds a result and the output register is full and not taken.
// Reset: synchronous, active high; clears valid bits and all four homography
// registers to zero.
module camera_intrinsic_constraint_residuals (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // focal_x, focal_y, center_x, center_y
   input  logic [cicr_pkg::REQ_W-1:0]          req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // sq_err_orth_one, sq_err_orth_two, sq_err_norm_one, sq_err_norm_two, total_score
   output logic [cicr_pkg::RSP_W-1:0]          rsp_tdata,
   // invalid
   output logic [0:0]                          rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cicr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cicr_pkg::CFG_W-1:0]          csr_data
);

   localparam int unsigned IN_W   = cicr_pkg::IN_W;
   localparam int unsigned ENT_W  = cicr_pkg::ENT_W;
   localparam int unsigned NC     = cicr_pkg::NUM_COLS;
   localparam int unsigned PRD_W  = cicr_pkg::PRD_W;
   localparam int unsigned A_W    = cicr_pkg::A_W;
   localparam int unsigned MAG_W  = cicr_pkg::MAG_W;
   localparam int unsigned QUO_W  = cicr_pkg::QUO_W;
   localparam int unsigned PROD_W = cicr_pkg::PROD_W;
   localparam int unsigned WIDE_W = cicr_pkg::WIDE_W;
   localparam int unsigned HH_W   = cicr_pkg::HH_W;
   localparam int unsigned SQ_W   = cicr_pkg::SQ_W;
   localparam int unsigned SQP_W  = cicr_pkg::SQP_W;
   localparam int unsigned OUT_W  = cicr_pkg::OUT_W;
   localparam int unsigned ND     = cicr_pkg::NUM_DOTS;
   localparam int unsigned NR     = cicr_pkg::NUM_RES;
   localparam int unsigned PIPE_LAT = 4 + QUO_W + 2 * cicr_pkg::MUL_LAT + 7;
   localparam int unsigned DU [ND] = '{0, 2, 0, 1, 2, 3};
   localparam int unsigned DV [ND] = '{1, 3, 0, 1, 2, 3};

   logic [cicr_pkg::CFG_W-1:0] cfg_ff [NC];
   logic [ENT_W-1:0] h0 [NC];
   logic [ENT_W-1:0] h1 [NC];
   logic [ENT_W-1:0] h2 [NC];

   logic en, out_load, in_fire;
   logic vld_ff [PIPE_LAT];
   logic inv_ff [PIPE_LAT];

   logic [IN_W-1:0] fx_ff, fy_ff, cx_ff, cy_ff;
   logic [IN_W-1:0] fx2_ff, fy2_ff, fx3_ff, fy3_ff, fx4_ff, fy4_ff;
   logic [PRD_W-1:0] prx_ff [NC];
   logic [PRD_W-1:0] pry_ff [NC];
   logic [A_W-1:0] ax_ff [NC];
   logic [A_W-1:0] ay_ff [NC];
   logic [QUO_W-1:0] nx_ff [NC];
   logic [QUO_W-1:0] ny_ff [NC];
   logic sx_ff [NC];
   logic sy_ff [NC];
   logic [QUO_W-1:0] nx_in [NC];
   logic [QUO_W-1:0] ny_in [NC];

   logic [QUO_W-1:0] qm [NC][2];
   logic qs [NC][2];
   logic [PROD_W-1:0] pm [ND][2];
   logic ps [ND][2];

   logic [WIDE_W-1:0] term_ff [ND][3];
   logic [WIDE_W-1:0] term_in [ND][3];
   logic [WIDE_W-1:0] dot_ff [ND];
   logic [WIDE_W-1:0] res_ff [NR];
   logic [SQ_W-1:0]   rmag_ff [NR];
   logic              rsat_ff [NR];
   logic [SQ_W-1:0]   rmag_in [NR];
   logic              rsat_in [NR];
   logic [SQP_W-1:0]  sq [NR];
   logic              sqsat [NR];
   logic [OUT_W-1:0]  s1_ff [NR];
   logic [OUT_W-1:0]  s1_in [NR];
   logic [OUT_W-1:0]  s2_ff [NR];
   logic [OUT_W-1:0]  s3_ff [NR];
   logic [OUT_W-1:0]  pair_ff [2];
   logic [OUT_W-1:0]  pair_in [2];
   logic [OUT_W-1:0]  total_ff, total_in;

   logic                       rsp_valid_ff;
   logic [cicr_pkg::RSP_W-1:0] rsp_data_ff;
   logic                       rsp_user_ff;

   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign en         = !vld_ff[PIPE_LAT-1] || out_load;
   assign req_tready = en;
   assign in_fire    = req_tvalid && en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NC; c++) cfg_ff[c] <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            cicr_pkg::CSR_VIEW1_COL0: cfg_ff[0] <= csr_data;
            cicr_pkg::CSR_VIEW1_COL1: cfg_ff[1] <= csr_data;
            cicr_pkg::CSR_VIEW2_COL0: cfg_ff[2] <= csr_data;
            cicr_pkg::CSR_VIEW2_COL1: cfg_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         h0[c] = cicr_pkg::entry_of(cfg_ff[c], 0);
         h1[c] = cicr_pkg::entry_of(cfg_ff[c], 1);
         h2[c] = cicr_pkg::entry_of(cfg_ff[c], 2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LAT; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < PIPE_LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         inv_ff[0] <= (req_tdata[IN_W-1:0] == '0) || (req_tdata[2*IN_W-1:IN_W] == '0);
         for (int i = 1; i < PIPE_LAT; i++) inv_ff[i] <= inv_ff[i-1];
      end
   end

   // center times third entry, numerator, rounded dividend
   always_comb begin
      logic [A_W-1:0] mx, my;
      for (int c = 0; c < NC; c++) begin
         mx = ax_ff[c][A_W-1] ? (~ax_ff[c] + 1'b1) : ax_ff[c];
         my = ay_ff[c][A_W-1] ? (~ay_ff[c] + 1'b1) : ay_ff[c];
         nx_in[c] = {mx[MAG_W-1:0], {cicr_pkg::FRAC_SH{1'b0}}}
                  + {{(QUO_W-IN_W+1){1'b0}}, fx3_ff[IN_W-1:1]};
         ny_in[c] = {my[MAG_W-1:0], {cicr_pkg::FRAC_SH{1'b0}}}
                  + {{(QUO_W-IN_W+1){1'b0}}, fy3_ff[IN_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (in_fire) begin
            fx_ff <= req_tdata[IN_W-1:0];
            fy_ff <= req_tdata[2*IN_W-1:IN_W];
            cx_ff <= req_tdata[3*IN_W-1:2*IN_W];
            cy_ff <= req_tdata[4*IN_W-1:3*IN_W];
         end
         fx2_ff <= fx_ff;
         fy2_ff <= fy_ff;
         fx3_ff <= fx2_ff;
         fy3_ff <= fy2_ff;
         fx4_ff <= fx3_ff;
         fy4_ff <= fy3_ff;
         for (int c = 0; c < NC; c++) begin
            prx_ff[c] <= {{(PRD_W-IN_W){1'b0}}, cx_ff}
                       * {{(PRD_W-ENT_W){h2[c][ENT_W-1]}}, h2[c]};
            pry_ff[c] <= {{(PRD_W-IN_W){1'b0}}, cy_ff}
                       * {{(PRD_W-ENT_W){h2[c][ENT_W-1]}}, h2[c]};
            ax_ff[c] <= ({{(A_W-ENT_W){h0[c][ENT_W-1]}}, h0[c]} << 8)
                      - {prx_ff[c][PRD_W-1], prx_ff[c]};
            ay_ff[c] <= ({{(A_W-ENT_W){h1[c][ENT_W-1]}}, h1[c]} << 8)
                      - {pry_ff[c][PRD_W-1], pry_ff[c]};
            nx_ff[c] <= nx_in[c];
            ny_ff[c] <= ny_in[c];
            sx_ff[c] <= ax_ff[c][A_W-1];
            sy_ff[c] <= ay_ff[c][A_W-1];
         end
      end
   end

   for (genvar c = 0; c < NC; c++) begin : g_div
      cicr_div #(.NW(QUO_W), .DW(IN_W), .TW(1)) u_div_x (
         .clock(clock), .en(en), .dividend(nx_ff[c]), .divisor(fx4_ff),
         .tag(sx_ff[c]), .quotient(qm[c][0]), .tag_out(qs[c][0])
      );
      cicr_div #(.NW(QUO_W), .DW(IN_W), .TW(1)) u_div_y (
         .clock(clock), .en(en), .dividend(ny_ff[c]), .divisor(fy4_ff),
         .tag(sy_ff[c]), .quotient(qm[c][1]), .tag_out(qs[c][1])
      );
   end

   for (genvar d = 0; d < ND; d++) begin : g_dot
      for (genvar k = 0; k < 2; k++) begin : g_term
         cicr_mul #(.W(QUO_W), .TW(1)) u_mul (
            .clock(clock), .en(en), .a(qm[DU[d]][k]), .b(qm[DV[d]][k]),
            .tag(qs[DU[d]][k] ^ qs[DV[d]][k]), .prod(pm[d][k]), .tag_out(ps[d][k])
         );
      end
   end

   // signed terms; third term is h2*h2' scaled by 2^32
   always_comb begin
      logic [WIDE_W-1:0] ext;
      logic [HH_W-1:0]   hh;
      for (int d = 0; d < ND; d++) begin
         for (int k = 0; k < 2; k++) begin
            ext = {{(WIDE_W-PROD_W){1'b0}}, pm[d][k]};
            term_in[d][k] = ps[d][k] ? (~ext + 1'b1) : ext;
         end
         hh = {{ENT_W{h2[DU[d]][ENT_W-1]}}, h2[DU[d]]}
            * {{ENT_W{h2[DV[d]][ENT_W-1]}}, h2[DV[d]]};
         term_in[d][2] = {{(WIDE_W-HH_W-cicr_pkg::HH_SH){hh[HH_W-1]}}, hh,
                          {cicr_pkg::HH_SH{1'b0}}};
      end
   end

   always_comb begin
      logic [WIDE_W-1:0] m;
      for (int r = 0; r < NR; r++) begin
         m = res_ff[r][WIDE_W-1] ? (~res_ff[r] + 1'b1) : res_ff[r];
         rsat_in[r] = (m[WIDE_W-1:SQ_W] != '0);
         rmag_in[r] = m[SQ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         term_ff <= term_in;
         for (int d = 0; d < ND; d++)
            dot_ff[d] <= term_ff[d][0] + term_ff[d][1] + term_ff[d][2];
         res_ff[0] <= dot_ff[0];
         res_ff[1] <= dot_ff[1];
         res_ff[2] <= dot_ff[2] - dot_ff[3];
         res_ff[3] <= dot_ff[4] - dot_ff[5];
         rmag_ff <= rmag_in;
         rsat_ff <= rsat_in;
      end
   end

   for (genvar r = 0; r < NR; r++) begin : g_sq
      cicr_mul #(.W(SQ_W), .TW(1)) u_sq (
         .clock(clock), .en(en), .a(rmag_ff[r]), .b(rmag_ff[r]),
         .tag(rsat_ff[r]), .prod(sq[r]), .tag_out(sqsat[r])
      );
   end

   always_comb begin
      logic [SQP_W:0]  rnd;
      logic [OUT_W:0]  ps0, ps1, pt;
      for (int r = 0; r < NR; r++) begin
         rnd = {1'b0, sq[r]} + ((SQP_W+1)'(1) << (cicr_pkg::RND_SH - 1));
         s1_in[r] = sqsat[r] ? '1 : rnd[SQP_W-1:cicr_pkg::RND_SH];
      end
      ps0 = {1'b0, s1_ff[0]} + {1'b0, s1_ff[1]};
      ps1 = {1'b0, s1_ff[2]} + {1'b0, s1_ff[3]};
      pair_in[0] = ps0[OUT_W] ? '1 : ps0[OUT_W-1:0];
      pair_in[1] = ps1[OUT_W] ? '1 : ps1[OUT_W-1:0];
      pt = {1'b0, pair_ff[0]} + {1'b0, pair_ff[1]};
      total_in = pt[OUT_W] ? '1 : pt[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff   <= s1_in;
         s2_ff   <= s1_ff;
         pair_ff <= pair_in;
         s3_ff   <= s2_ff;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= vld_ff[PIPE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && vld_ff[PIPE_LAT-1]) begin
         rsp_user_ff <= inv_ff[PIPE_LAT-1];
         if (inv_ff[PIPE_LAT-1]) begin
            rsp_data_ff <= '0;
         end else begin
            rsp_data_ff <= {total_ff, s3_ff[3], s3_ff[2], s3_ff[1], s3_ff[0]};
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

endmodule

### rtl/core/cicr_chk.sv
`include "camera_intrinsic_constraint_residuals_defines.svh"

module cicr_chk (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [cicr_pkg::RSP_W-1:0] rsp_tdata,
   input logic [0:0]                 rsp_tuser
);

   `CICR_AST_RESET(a_rst_idle, !rsp_tvalid)
   `CICR_AST_NEXT(a_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `CICR_AST_SAME(a_inv_zero, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0)
   `CICR_AST_SAME(a_total_ge, rsp_tvalid, rsp_tdata[319:256] >= rsp_tdata[63:0])

endmodule

bind camera_intrinsic_constraint_residuals cicr_chk u_cicr_chk (
   .clock(clock),
   .reset(reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);
